@@ src/pqmf_pkg.sv @@
// pqmf_pkg: shared constants, codes and types for the min-first priority queue
// used by the queue cells, the top level and the port checker
package pqmf_pkg;

  localparam int DEPTH  = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int PRI_W  = 16;
  localparam int CAP_W  = 6;
  localparam int OCC_W  = 6;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  // request kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ENQUEUED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DEQUEUED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd3;

  // cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_REMOVE = 2'd2;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic        [1:0]       op;
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] prio;
  } cell_ctrl_t;

endpackage

@@ src/priority_queue_min_first_unit.sv @@
// priority_queue_min_first_unit: top level of the min-first priority queue
// depends on pqmf_pkg and pqmf_cell
//
// Bounded priority queue held as a row of DEPTH sorted cells (32 entries).
// Every cell compares its own priority with the incoming one, so an enqueue
// drops into place and a dequeue pulls the whole row one slot toward the
// head. A request is taken every cycle while the result side keeps up; its
// result shows up on the out_ channel in the cycle after the input transfer
// and sits in an output register. While that result waits, in_stall is high
// (it only rises when the output register is full and out_stall is high),
// and the next request is taken in the same cycle the waiting result
// transfers out. Smaller priority numbers leave first, and equal priorities
// leave in arrival order.
// Enqueue on a full queue (occupancy at capacity, or at DEPTH) reports
// overflow, dequeue on an empty one reports underflow; neither changes the
// contents. Capacity is written through the cfg_ port, which is always ready,
// and should only change while no request is in flight.
module priority_queue_min_first_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // request channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_kind,
  input  logic signed [pqmf_pkg::VAL_W-1:0]       in_item_value,
  input  logic        [pqmf_pkg::PRI_W-1:0]       in_item_priority,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic        [pqmf_pkg::STAT_W-1:0]      out_status,
  output logic signed [pqmf_pkg::VAL_W-1:0]       out_value,
  output logic        [pqmf_pkg::PRI_W-1:0]       out_priority,
  output logic        [pqmf_pkg::OCC_W-1:0]       out_occupancy,
  // capacity register write
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [pqmf_pkg::CAP_W-1:0]       cfg_data
);
  import pqmf_pkg::*;

  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic [PRI_W-1:0]  prio_r, prio_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  logic              in_xfer;
  logic              out_xfer;
  logic              full;
  cell_ctrl_t        ctrl;

  entry_t            cell_entry [DEPTH];
  logic              cell_gt    [DEPTH];

  // output register frees up when empty or being drained this cycle
  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  // full at the configured capacity or at the physical depth
  assign full = (int'(count_r) >= int'(cap_r)) || (int'(count_r) >= DEPTH);

  // decode request into a chain-wide operation and result fields
  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = in_item_value;
    ctrl.prio  = in_item_priority;
    count_nxt  = count_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    prio_nxt   = prio_r;
    if (in_xfer) begin
      value_nxt = '0;
      prio_nxt  = '0;
      if (in_kind == KIND_ENQ) begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          ctrl.op    = CELL_INSERT;
          count_nxt  = count_r + CNT_W'(1);
          status_nxt = ST_ENQUEUED;
        end
      end else begin
        if (!cell_entry[0].valid) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          ctrl.op    = CELL_REMOVE;
          count_nxt  = count_r - CNT_W'(1);
          status_nxt = ST_DEQUEUED;
          value_nxt  = cell_entry[0].value;
          prio_nxt   = cell_entry[0].prio;
        end
      end
    end
    occ_nxt = in_xfer ? OCC_W'(count_nxt) : occ_r;
  end

  // result register valid: set on a request, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  // the sorted cell row, head at index 0
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   left_g;
      if (gi == 0) begin : g_head
        // head sees an always-occupied, never-greater neighbor
        assign left_e.valid = 1'b1;
        assign left_e.value = '0;
        assign left_e.prio  = '0;
        assign left_g       = 1'b0;
      end else begin : g_mid
        assign left_e = cell_entry[gi-1];
        assign left_g = cell_gt[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        // tail pulls in an empty slot on removal
        assign right_e.valid = 1'b0;
        assign right_e.value = '0;
        assign right_e.prio  = '0;
      end else begin : g_body
        assign right_e = cell_entry[gi+1];
      end
      pqmf_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .left_entry (left_e),
        .left_gt    (left_g),
        .right_entry(right_e),
        .entry      (cell_entry[gi]),
        .gt         (cell_gt[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    value_r  <= value_nxt;
    prio_r   <= prio_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_value     = value_r;
  assign out_priority  = prio_r;
  assign out_occupancy = occ_r;

endmodule

@@ src/pqmf_cell.sv @@
// pqmf_cell: one slot of the sorted shift chain
// depends on pqmf_pkg for entry and control types
module pqmf_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  pqmf_pkg::cell_ctrl_t ctrl,
  input  pqmf_pkg::entry_t    left_entry,
  input  logic                left_gt,
  input  pqmf_pkg::entry_t    right_entry,
  output pqmf_pkg::entry_t    entry,
  output logic                gt
);
  import pqmf_pkg::*;

  logic                    valid_r, valid_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic        [PRI_W-1:0] prio_r, prio_nxt;
  logic                    ins_here;

  // entry strictly after the new item in sorted order
  assign gt       = valid_r && (prio_r > ctrl.prio);
  // new item lands here: first greater entry, or first free slot
  assign ins_here = gt || (!valid_r && left_entry.valid);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (left_gt) begin
          valid_nxt = left_entry.valid;
          value_nxt = left_entry.value;
          prio_nxt  = left_entry.prio;
        end else if (ins_here) begin
          valid_nxt = 1'b1;
          value_nxt = ctrl.value;
          prio_nxt  = ctrl.prio;
        end
      end
      CELL_REMOVE: begin
        valid_nxt = right_entry.valid;
        value_nxt = right_entry.value;
        prio_nxt  = right_entry.prio;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign entry.valid = valid_r;
  assign entry.value = value_r;
  assign entry.prio  = prio_r;

endmodule

@@ src/pqmf_checker.sv @@
// pqmf_checker: port-level checks of the min-first priority queue
// depends on pqmf_pkg; bound to priority_queue_min_first_unit below
module pqmf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic        [pqmf_pkg::STAT_W-1:0]  out_status,
  input logic signed [pqmf_pkg::VAL_W-1:0]   out_value,
  input logic        [pqmf_pkg::PRI_W-1:0]   out_priority,
  input logic        [pqmf_pkg::OCC_W-1:0]   out_occupancy
);
  import pqmf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_value) && $stable(out_priority) && $stable(out_occupancy))
    else $error("stalled result changed");

  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

  // a transfer in gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  // underflow only on an empty queue, and only dequeues carry data
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDERFLOW |-> out_occupancy == '0)
    else $error("underflow with entries held");

  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DEQUEUED |-> out_value == '0 && out_priority == '0)
    else $error("data returned without a dequeue");

endmodule

bind priority_queue_min_first_unit pqmf_checker u_pqmf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_status   (out_status),
  .out_value    (out_value),
  .out_priority (out_priority),
  .out_occupancy(out_occupancy)
);
